// ----- sv/wfq_pkg.sv -----
// Shared types, constants and codes for the WF2Q+ calendar scheduler.
`default_nettype none

package wfq_pkg;

    // Table and calendar sizes.
    localparam int MAX_SESSIONS = 64;
    localparam int MAX_BINS     = 1024;
    localparam int SLOT_AW      = $clog2(MAX_SESSIONS);
    localparam int SCAN_CW      = SLOT_AW + 1;

    // Field widths.
    localparam int TIME_W     = 64;
    localparam int BIN_W      = 10;
    localparam int AGE_W      = 16;
    localparam int BASE_W     = 32;
    localparam int BPG_W      = 7;
    localparam int BIU_W      = 11;
    localparam int GROUP_W    = 4;
    localparam int SHIFT_W    = GROUP_W + 1;
    localparam int CALC_BIN_W = 12;
    localparam int DIV_CW     = $clog2(TIME_W) + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 208;
    localparam int M_TDATA_W  = 152;

    // Reset values of the configuration registers.
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1);
    localparam logic [BPG_W-1:0]  BPG_RESET  = BPG_W'(4);
    localparam logic [BIU_W-1:0]  BIU_RESET  = BIU_W'(64);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_SET_VT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_BAD_ID  = 2'd1,
        RES_BAD_BIN = 2'd2
    } res_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_INTERVAL  = 2'd0,
        CFG_BINS_PER_GROUP = 2'd1,
        CFG_BINS_IN_USE    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_SIZE = 2'd0,
        DIV_MOD  = 2'd1,
        DIV_OFF  = 2'd2
    } div_sel_t;

    typedef enum logic {
        SCAN_FIND  = 1'b0,
        SCAN_LEAST = 1'b1
    } scan_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_SIZE,
        ST_DIV_MOD,
        ST_DIV_OFF,
        ST_INSERT,
        ST_RM_CHECK,
        ST_RECOUNT,
        ST_FIND1,
        ST_FIND2,
        ST_DONE
    } state_t;

    // One stored session.
    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] finish;
        logic [BIN_W-1:0]  bin;
        logic [AGE_W-1:0]  age;
    } slot_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        capture;
        logic        div_start;
        div_sel_t    div_sel;
        logic        save_size;
        logic        save_off;
        logic        zero_off;
        logic        ins_commit;
        logic        status_we;
        res_status_t status_val;
        logic        rd_id;
        logic        rm_commit;
        logic        scan_start;
        scan_mode_t  scan_mode;
        logic        scan_run;
        logic        least_load;
        logic        vt_jump;
        logic        vt_set;
        logic        out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_t req;
        logic id_bad;
        logic slot_busy;
        logic trivial_bin;
        logic div_idle;
        logic bin_bad;
        logic rm_bin_bad;
        logic rm_is_least;
        logic scan_done;
        logic any_found;
        logic least_none;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/wf2q_calendar_scheduler.sv -----
// Each request is accepted in idle and decoded; its result is valid on the return to idle.
// Set virtual time or bad id: no more steps. Remove: a slot read, and a table scan when
// the least start is recounted. Insert: three divider passes, none with a trivial bin.
// Find: one table scan, and a second one when nothing is eligible and time jumps.
// One request at a time; a full result register holds the next result back.
// Synchronous active-low reset empties the table, zeroes virtual time and loads defaults.
`default_nettype none

module wf2q_calendar_scheduler (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wfq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wfq_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Request channel.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // session_id[5:0], start[69:6], finish[133:70], group[137:134],
    // new_virtual_time[201:138], zero fill[207:202]
    input  wire logic [wfq_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                          s_tuser,
    // Result channel.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // found[0], chosen_session[6:1], chosen_finish[70:7], placed_bin[80:71],
    // vtime_now[144:81], zero fill[151:145]
    output logic [wfq_pkg::M_TDATA_W-1:0]            m_tdata,
    // status[1:0]
    output logic [1:0]                               m_tuser
);
    import wfq_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic        out_found;
    logic [5:0]  out_chosen_session;
    logic [63:0] out_chosen_finish;
    logic [9:0]  out_placed_bin;
    logic [63:0] out_vtime_now;

    assign cfg_ready = 1'b1;

    wfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wfq_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_valid && cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_req_type         (s_tuser),
        .in_session_id       (s_tdata[5:0]),
        .in_start            (s_tdata[69:6]),
        .in_finish           (s_tdata[133:70]),
        .in_group            (s_tdata[137:134]),
        .in_new_virtual_time (s_tdata[201:138]),
        .cmd                 (cmd),
        .stat                (stat),
        .out_status          (m_tuser),
        .out_found           (out_found),
        .out_chosen_session  (out_chosen_session),
        .out_chosen_finish   (out_chosen_finish),
        .out_placed_bin      (out_placed_bin),
        .out_vtime_now       (out_vtime_now)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {7'b0, out_vtime_now, out_placed_bin, out_chosen_finish,
                      out_chosen_session, out_found};

endmodule

`default_nettype wire

// ----- sv/wfq_dp.sv -----
// Datapath: configuration, session table, divider, table scanner and result registers.
`default_nettype none

module wfq_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [wfq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wfq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [1:0]                      in_req_type,
    input  wire logic [5:0]                      in_session_id,
    input  wire logic [63:0]                     in_start,
    input  wire logic [63:0]                     in_finish,
    input  wire logic [3:0]                      in_group,
    input  wire logic [63:0]                     in_new_virtual_time,
    input  wire wfq_pkg::cmd_t                   cmd,
    output wfq_pkg::stat_t                       stat,
    output logic [1:0]                           out_status,
    output logic                                 out_found,
    output logic [5:0]                           out_chosen_session,
    output logic [63:0]                          out_chosen_finish,
    output logic [9:0]                           out_placed_bin,
    output logic [63:0]                          out_vtime_now
);
    import wfq_pkg::*;

    // Configuration registers.
    logic [BASE_W-1:0] base_reg;
    logic [BPG_W-1:0]  bpg_reg;
    logic [BIU_W-1:0]  biu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
            bpg_reg  <= BPG_RESET;
            biu_reg  <= BIU_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE_INTERVAL:  base_reg <= cfg_data[BASE_W-1:0];
                CFG_BINS_PER_GROUP: bpg_reg  <= cfg_data[BPG_W-1:0];
                CFG_BINS_IN_USE:    biu_reg  <= cfg_data[BIU_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured request.
    req_t               req_reg;
    logic [SLOT_AW-1:0] sid_reg;
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  finish_reg;
    logic [GROUP_W-1:0] group_reg;
    logic [TIME_W-1:0]  nvt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg    <= req_t'(in_req_type);
            sid_reg    <= in_session_id;
            start_reg  <= in_start;
            finish_reg <= in_finish;
            group_reg  <= in_group;
            nvt_reg    <= in_new_virtual_time;
        end
    end

    // Scheduler state registers.
    logic [MAX_SESSIONS-1:0] valid_reg;
    logic [AGE_W-1:0]        counter_reg;
    logic [TIME_W-1:0]       vt_reg;
    logic [TIME_W-1:0]       least_reg;
    logic [TIME_W-1:0]       acc_reg;

    // Session table memory with a registered read port.
    slot_t              mem [MAX_SESSIONS];
    slot_t              rdata_reg;
    slot_t              wdata;
    logic [SLOT_AW-1:0] raddr;
    logic [SCAN_CW-1:0] idx_reg;

    // Bin computation.
    logic [CALC_BIN_W-1:0] bin_calc;
    logic [BPG_W-1:0]      off_reg;

    assign raddr = cmd.rd_id ? sid_reg : idx_reg[SLOT_AW-1:0];
    assign wdata = '{start: start_reg, finish: finish_reg,
                     bin: bin_calc[BIN_W-1:0], age: counter_reg};

    always_ff @(posedge aclk) begin
        if (cmd.ins_commit) begin
            mem[sid_reg] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Restoring divider, one quotient bit per cycle.
    logic [TIME_W-1:0] div_rem_reg;
    logic [TIME_W-1:0] div_quo_reg;
    logic [TIME_W-1:0] div_dvs_reg;
    logic [DIV_CW-1:0] div_cnt_reg;
    logic [TIME_W-1:0] size_reg;
    logic [TIME_W-1:0] range_val;
    logic [TIME_W-1:0] dvd_sel;
    logic [TIME_W-1:0] dvs_sel;
    logic [SHIFT_W-1:0] shamt;
    logic [TIME_W:0]   div_trial;
    logic [TIME_W:0]   div_diff;

    assign shamt     = SHIFT_W'(group_reg) + SHIFT_W'(1);
    assign range_val = TIME_W'(base_reg) << shamt;
    assign div_trial = {div_rem_reg, div_quo_reg[TIME_W-1]};
    assign div_diff  = div_trial - {1'b0, div_dvs_reg};

    always_comb begin
        unique case (cmd.div_sel)
            DIV_SIZE: begin
                dvd_sel = range_val;
                dvs_sel = TIME_W'(bpg_reg);
            end
            DIV_MOD: begin
                dvd_sel = finish_reg;
                dvs_sel = range_val;
            end
            DIV_OFF: begin
                dvd_sel = div_rem_reg;
                dvs_sel = size_reg;
            end
            default: begin
                dvd_sel = finish_reg;
                dvs_sel = range_val;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= DIV_CW'(TIME_W);
        end else if (div_cnt_reg != '0) begin
            div_cnt_reg <= div_cnt_reg - DIV_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_rem_reg <= '0;
            div_quo_reg <= dvd_sel;
            div_dvs_reg <= dvs_sel;
        end else if (div_cnt_reg != '0) begin
            if (!div_diff[TIME_W]) begin
                div_rem_reg <= div_diff[TIME_W-1:0];
                div_quo_reg <= {div_quo_reg[TIME_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= div_trial[TIME_W-1:0];
                div_quo_reg <= {div_quo_reg[TIME_W-2:0], 1'b0};
            end
        end
    end

    // Bin size is at least one; in-group bin is clamped to the last bin.
    always_ff @(posedge aclk) begin
        if (cmd.save_size) begin
            size_reg <= (div_quo_reg == '0) ? TIME_W'(1) : div_quo_reg;
        end
        if (cmd.zero_off) begin
            off_reg <= '0;
        end else if (cmd.save_off) begin
            off_reg <= (div_quo_reg >= TIME_W'(bpg_reg)) ? (bpg_reg - BPG_W'(1))
                                                         : div_quo_reg[BPG_W-1:0];
        end
    end

    assign bin_calc = CALC_BIN_W'(group_reg) * CALC_BIN_W'(bpg_reg) + CALC_BIN_W'(off_reg);

    // Table scanner: one slot enters per cycle, its data returns from the registered read port.
    logic               pv_reg;
    logic [SLOT_AW-1:0] pidx_reg;
    scan_mode_t         mode_reg;
    logic               any_reg;
    logic [SLOT_AW-1:0] best_idx_reg;
    logic [TIME_W-1:0]  best_fin_reg;
    logic [BIN_W-1:0]   best_bin_reg;
    logic [TIME_W-1:0]  best_start_reg;
    logic [AGE_W-1:0]   best_new_reg;
    logic               cur_counted;
    logic               cur_eligible;
    logic               cur_better;
    logic [AGE_W-1:0]   cur_new;

    assign cur_counted  = valid_reg[pidx_reg] && ({1'b0, rdata_reg.bin} < biu_reg);
    assign cur_eligible = cur_counted && (rdata_reg.start <= vt_reg);
    assign cur_new      = counter_reg - rdata_reg.age;

    // Order: least finish, then lowest bin, then smaller start, then newest.
    always_comb begin
        if (rdata_reg.finish != best_fin_reg) begin
            cur_better = rdata_reg.finish < best_fin_reg;
        end else if (rdata_reg.bin != best_bin_reg) begin
            cur_better = rdata_reg.bin < best_bin_reg;
        end else if (rdata_reg.start != best_start_reg) begin
            cur_better = rdata_reg.start < best_start_reg;
        end else begin
            cur_better = cur_new < best_new_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            pv_reg  <= 1'b0;
        end else if (cmd.scan_start) begin
            idx_reg <= '0;
            pv_reg  <= 1'b0;
        end else if (cmd.scan_run) begin
            if (idx_reg != SCAN_CW'(MAX_SESSIONS)) begin
                idx_reg <= idx_reg + SCAN_CW'(1);
                pv_reg  <= 1'b1;
            end else begin
                pv_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= idx_reg[SLOT_AW-1:0];
        if (cmd.scan_start) begin
            mode_reg <= cmd.scan_mode;
            any_reg  <= 1'b0;
            acc_reg  <= '1;
        end else if (cmd.scan_run && pv_reg) begin
            if (mode_reg == SCAN_FIND) begin
                if (cur_eligible && (!any_reg || cur_better)) begin
                    any_reg        <= 1'b1;
                    best_idx_reg   <= pidx_reg;
                    best_fin_reg   <= rdata_reg.finish;
                    best_bin_reg   <= rdata_reg.bin;
                    best_start_reg <= rdata_reg.start;
                    best_new_reg   <= cur_new;
                end
            end else if (cur_counted && (rdata_reg.start < acc_reg)) begin
                acc_reg <= rdata_reg.start;
            end
        end
    end

    // Valid bits, insert counter, virtual time and least start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            counter_reg <= '0;
            vt_reg      <= '0;
            least_reg   <= '1;
        end else begin
            if (cmd.ins_commit) begin
                valid_reg[sid_reg] <= 1'b1;
                counter_reg        <= counter_reg + AGE_W'(1);
                if (start_reg < least_reg) begin
                    least_reg <= start_reg;
                end
            end
            if (cmd.rm_commit) begin
                valid_reg[sid_reg] <= 1'b0;
            end
            if (cmd.least_load) begin
                least_reg <= acc_reg;
            end
            if (cmd.vt_set) begin
                vt_reg <= nvt_reg;
            end else if (cmd.vt_jump && (least_reg > vt_reg)) begin
                vt_reg <= least_reg;
            end
        end
    end

    // Per-request result fields.
    res_status_t      res_status_reg;
    logic [BIN_W-1:0] res_placed_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_status_reg <= RES_OK;
            res_placed_reg <= '0;
        end else begin
            if (cmd.status_we) begin
                res_status_reg <= cmd.status_val;
            end
            if (cmd.ins_commit) begin
                res_placed_reg <= bin_calc[BIN_W-1:0];
            end
        end
    end

    // Output register.
    logic found_now;

    assign found_now = (req_reg == REQ_FIND) && any_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status         <= res_status_reg;
            out_found          <= found_now;
            out_chosen_session <= found_now ? best_idx_reg : '0;
            out_chosen_finish  <= found_now ? best_fin_reg : '0;
            out_placed_bin     <= res_placed_reg;
            out_vtime_now      <= vt_reg;
        end
    end

    // Status toward the controller.
    assign stat.req         = req_reg;
    assign stat.id_bad      = (int'(sid_reg) >= MAX_SESSIONS);
    assign stat.slot_busy   = valid_reg[sid_reg];
    assign stat.trivial_bin = (bpg_reg == '0) || (base_reg == '0);
    assign stat.div_idle    = (div_cnt_reg == '0);
    assign stat.bin_bad     = (bin_calc >= CALC_BIN_W'(biu_reg))
                              || (bin_calc >= CALC_BIN_W'(MAX_BINS));
    assign stat.rm_bin_bad  = ({1'b0, rdata_reg.bin} >= biu_reg);
    assign stat.rm_is_least = (rdata_reg.start == least_reg);
    assign stat.scan_done   = (idx_reg == SCAN_CW'(MAX_SESSIONS)) && !pv_reg;
    assign stat.any_found   = any_reg;
    assign stat.least_none  = (least_reg == '1);

endmodule

`default_nettype wire

// ----- sv/wfq_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module wfq_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire wfq_pkg::stat_t stat,
    output wfq_pkg::cmd_t       cmd
);
    import wfq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.req)
                    REQ_INSERT: begin
                        if (stat.id_bad || stat.slot_busy) begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = RES_BAD_ID;
                            state_next     = ST_DONE;
                        end else if (stat.trivial_bin) begin
                            cmd.zero_off = 1'b1;
                            state_next   = ST_INSERT;
                        end else begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_SIZE;
                            state_next    = ST_DIV_SIZE;
                        end
                    end
                    REQ_REMOVE: begin
                        if (stat.id_bad || !stat.slot_busy) begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = RES_BAD_ID;
                            state_next     = ST_DONE;
                        end else begin
                            cmd.rd_id  = 1'b1;
                            state_next = ST_RM_CHECK;
                        end
                    end
                    REQ_FIND: begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_FIND;
                        state_next     = ST_FIND1;
                    end
                    REQ_SET_VT: begin
                        cmd.vt_set = 1'b1;
                        state_next = ST_DONE;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_DIV_SIZE: begin
                if (stat.div_idle) begin
                    cmd.save_size = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MOD;
                    state_next    = ST_DIV_MOD;
                end
            end
            ST_DIV_MOD: begin
                if (stat.div_idle) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_OFF;
                    state_next    = ST_DIV_OFF;
                end
            end
            ST_DIV_OFF: begin
                if (stat.div_idle) begin
                    cmd.save_off = 1'b1;
                    state_next   = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (stat.bin_bad) begin
                    cmd.status_we  = 1'b1;
                    cmd.status_val = RES_BAD_BIN;
                end else begin
                    cmd.ins_commit = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_RM_CHECK: begin
                if (stat.rm_bin_bad) begin
                    cmd.status_we  = 1'b1;
                    cmd.status_val = RES_BAD_BIN;
                    state_next     = ST_DONE;
                end else begin
                    cmd.rm_commit = 1'b1;
                    if (stat.rm_is_least) begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_LEAST;
                        state_next     = ST_RECOUNT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RECOUNT: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    cmd.least_load = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_FIND1: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    if (stat.any_found || stat.least_none) begin
                        state_next = ST_DONE;
                    end else begin
                        // Nothing eligible: jump virtual time and search again.
                        cmd.vt_jump    = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_FIND;
                        state_next     = ST_FIND2;
                    end
                end
            end
            ST_FIND2: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ----- tb/tb_wf2q_calendar_scheduler.sv -----
// Self-checking testbench for the WF2Q+ calendar scheduler, with a built-in predictor.
`timescale 1ns / 1ps

module tb_wf2q_calendar_scheduler;
    import wfq_pkg::*;

    typedef struct packed {
        res_status_t       status;
        logic              found;
        logic [5:0]        chosen;
        logic [TIME_W-1:0] cfin;
        logic [BIN_W-1:0]  placed;
        logic [TIME_W-1:0] vtime;
    } sched_result_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    wf2q_calendar_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Shadow copy of the scheduler state and configuration.
    logic [BASE_W-1:0] sh_base;
    logic [BPG_W-1:0]  sh_bpg;
    logic [BIU_W-1:0]  sh_biu;
    logic              sh_valid [MAX_SESSIONS];
    logic [TIME_W-1:0] sh_start [MAX_SESSIONS];
    logic [TIME_W-1:0] sh_finish [MAX_SESSIONS];
    logic [BIN_W-1:0]  sh_bin [MAX_SESSIONS];
    logic [AGE_W-1:0]  sh_age [MAX_SESSIONS];
    logic [AGE_W-1:0]  sh_inserts;
    logic [TIME_W-1:0] sh_vtime;
    logic [TIME_W-1:0] sh_least;

    sched_result_t pending_results[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;
    int n_results = 0;
    int n_found = 0;
    int n_jumps = 0;
    int n_bad = 0;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #20ms;
        $display("Timeout at %0t", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic is_counted(int i);
        return sh_valid[i] && ({1'b0, sh_bin[i]} < sh_biu);
    endfunction

    // True if slot a is served before slot b.
    function automatic logic goes_first(int a, int b);
        logic [AGE_W-1:0] na, nb;
        na = sh_inserts - sh_age[a];
        nb = sh_inserts - sh_age[b];
        if (sh_finish[a] != sh_finish[b]) return sh_finish[a] < sh_finish[b];
        if (sh_bin[a] != sh_bin[b]) return sh_bin[a] < sh_bin[b];
        if (sh_start[a] != sh_start[b]) return sh_start[a] < sh_start[b];
        return na < nb;
    endfunction

    function automatic logic find_eligible(output int pick);
        logic any;
        any = 1'b0;
        pick = 0;
        for (int i = 0; i < MAX_SESSIONS; i++) begin
            if (is_counted(i) && sh_start[i] <= sh_vtime && (!any || goes_first(i, pick))) begin
                pick = i;
                any = 1'b1;
            end
        end
        return any;
    endfunction

    function automatic int calendar_bin(logic [TIME_W-1:0] finish, logic [3:0] grp);
        logic [TIME_W-1:0] range, size, off;
        off = '0;
        if (sh_bpg != 0 && sh_base != 0) begin
            range = {32'b0, sh_base} << (grp + 1);
            size = range / sh_bpg;
            if (size == 0) size = 1;
            off = (finish % range) / size;
            if (off >= sh_bpg) off = sh_bpg - 1;
        end
        return int'(grp) * int'(sh_bpg) + int'(off);
    endfunction

    // Applies one request to the shadow state and returns the expected result.
    function automatic sched_result_t schedule_step(req_t req, logic [5:0] id,
            logic [TIME_W-1:0] st, logic [TIME_W-1:0] fin, logic [3:0] grp,
            logic [TIME_W-1:0] nvt);
        sched_result_t r;
        int b, pick;
        logic any;
        r = '0;
        r.status = RES_OK;
        case (req)
            REQ_INSERT: begin
                if (sh_valid[id]) begin
                    r.status = RES_BAD_ID;
                end else begin
                    b = calendar_bin(fin, grp);
                    if (b >= int'(sh_biu) || b >= MAX_BINS) begin
                        r.status = RES_BAD_BIN;
                    end else begin
                        sh_valid[id] = 1'b1;
                        sh_start[id] = st;
                        sh_finish[id] = fin;
                        sh_bin[id] = b[BIN_W-1:0];
                        sh_age[id] = sh_inserts;
                        sh_inserts = sh_inserts + 1'b1;
                        if (st < sh_least) sh_least = st;
                        r.placed = b[BIN_W-1:0];
                    end
                end
            end
            REQ_REMOVE: begin
                if (!sh_valid[id]) begin
                    r.status = RES_BAD_ID;
                end else if ({1'b0, sh_bin[id]} >= sh_biu) begin
                    r.status = RES_BAD_BIN;
                end else begin
                    sh_valid[id] = 1'b0;
                    // Recount the least start when its holder leaves.
                    if (sh_start[id] == sh_least) begin
                        sh_least = '1;
                        for (int i = 0; i < MAX_SESSIONS; i++)
                            if (is_counted(i) && sh_start[i] < sh_least) sh_least = sh_start[i];
                    end
                end
            end
            REQ_FIND: begin
                any = find_eligible(pick);
                if (!any && sh_least != '1) begin
                    if (sh_least > sh_vtime) begin
                        sh_vtime = sh_least;
                        n_jumps++;
                    end
                    any = find_eligible(pick);
                end
                if (any) begin
                    r.found = 1'b1;
                    r.chosen = pick[5:0];
                    r.cfin = sh_finish[pick];
                end
            end
            default: sh_vtime = nvt;
        endcase
        r.vtime = sh_vtime;
        return r;
    endfunction

    // Sends one request and records its expected result once accepted.
    task automatic send_request(req_t req, logic [5:0] id, logic [TIME_W-1:0] st,
            logic [TIME_W-1:0] fin, logic [3:0] grp, logic [TIME_W-1:0] nvt);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {6'b0, nvt, grp, fin, st, id};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(schedule_step(req, id, st, fin, grp, nvt));
    endtask

    // Writes one register; the channel is lowered by the next request.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BASE_INTERVAL:  sh_base = value;
            CFG_BINS_PER_GROUP: sh_bpg = value[BPG_W-1:0];
            default:            sh_biu = value[BIU_W-1:0];
        endcase
    endtask

    task automatic set_calendar(logic [31:0] base, logic [6:0] bpg, logic [10:0] biu);
        write_reg(CFG_BASE_INTERVAL, base);
        write_reg(CFG_BINS_PER_GROUP, {25'b0, bpg});
        write_reg(CFG_BINS_IN_USE, {21'b0, biu});
    endtask

    // Waits until every expected result is back, then lets the block settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    function automatic logic [TIME_W-1:0] rand_time(logic [TIME_W-1:0] near);
        case ($urandom_range(9))
            0:       return {$urandom, $urandom};
            1:       return '1;
            2:       return near + $urandom_range(3);
            default: return near + $urandom_range(400);
        endcase
    endfunction

    task automatic send_random;
        req_t req;
        logic [5:0] id;
        int k;
        k = $urandom_range(99);
        req = k < 38 ? REQ_INSERT : k < 62 ? REQ_REMOVE : k < 92 ? REQ_FIND : REQ_SET_VT;
        id = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
        send_request(req, id, rand_time(sh_vtime), rand_time(sh_vtime), 4'($urandom),
                     ($urandom_range(3) == 0) ? {$urandom, $urandom} : rand_time(sh_vtime));
    endtask

    // Extremes, every request kind, error codes and tie-breaks.
    task automatic test_directed;
        send_request(REQ_FIND, 0, 0, 0, 0, 0);
        send_request(REQ_INSERT, 0, 0, 0, 0, 0);
        send_request(REQ_INSERT, 0, 5, 5, 0, 0);
        send_request(REQ_REMOVE, 63, 0, 0, 0, 0);
        send_request(REQ_INSERT, 63, 64'd10, '1, 4'd15, 0);
        send_request(REQ_INSERT, 1, 64'd10, 64'd7, 4'd0, 0);
        send_request(REQ_INSERT, 2, 64'd10, 64'd7, 4'd0, 0);
        send_request(REQ_FIND, 0, 0, 0, 0, 0);
        send_request(REQ_FIND, 0, 0, 0, 0, 0);
        send_request(REQ_REMOVE, 0, 0, 0, 0, 0);
        send_request(REQ_FIND, 0, 0, 0, 0, 0);
        send_request(REQ_INSERT, 5, '1, 64'd1, 4'd0, 0);
        send_request(REQ_SET_VT, 0, 0, 0, 0, '1);
        send_request(REQ_FIND, 0, 0, 0, 0, 0);
        send_request(REQ_SET_VT, 0, 0, 0, 0, 0);
        send_request(REQ_INSERT, 6, '1, '1, 4'd15, '1);
        drain();
        // Shrink the calendar under stored sessions.
        set_calendar(32'hFFFF_FFFF, 7'd64, 11'd8);
        send_request(REQ_REMOVE, 63, 0, 0, 0, 0);
        send_request(REQ_FIND, 0, 0, 0, 0, 0);
        send_request(REQ_INSERT, 7, 64'd3, '1, 4'd15, 0);
        drain();
        set_calendar(0, 7'd0, 11'd0);
        send_request(REQ_INSERT, 8, 0, 0, 0, 0);
        drain();
        set_calendar(0, 7'd0, 11'd1024);
        send_request(REQ_INSERT, 8, 0, 64'hAAAA, 4'd15, 0);
        send_request(REQ_REMOVE, 63, 0, 0, 0, 0);
        send_request(REQ_FIND, 0, 0, 0, 0, 0);
        drain();
    endtask

    // Random traffic under one calendar setting.
    task automatic test_random(int items, logic [31:0] base, logic [6:0] bpg, logic [10:0] biu);
        set_calendar(base, bpg, biu);
        repeat (items) send_random();
        drain();
    endtask

    // Receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure;
        hold_cycles = 600;
        repeat (80) send_random();
        drain();
    endtask

    // Result checker and receiver stalls.
    task automatic check_field(string name, logic [63:0] expv, logic [63:0] got);
        if (expv !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, got);
        end
    endtask

    initial begin
        sched_result_t e;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual %h %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    e = pending_results.pop_front();
                    n_results++;
                    if (e.found) n_found++;
                    if (e.status != RES_OK) n_bad++;
                    check_field("status", e.status, m_tuser);
                    check_field("found", e.found, m_tdata[0]);
                    check_field("chosen_session", e.chosen, m_tdata[6:1]);
                    check_field("chosen_finish", e.cfin, m_tdata[70:7]);
                    check_field("placed_bin", e.placed, m_tdata[80:71]);
                    check_field("vtime_now", e.vtime, m_tdata[144:81]);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        sh_base = BASE_RESET;
        sh_bpg = BPG_RESET;
        sh_biu = BIU_RESET;
        for (int i = 0; i < MAX_SESSIONS; i++) begin
            sh_valid[i] = 1'b0;
            sh_start[i] = '0;
            sh_finish[i] = '0;
            sh_bin[i] = '0;
            sh_age[i] = '0;
        end
        sh_inserts = '0;
        sh_vtime = '0;
        sh_least = '1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        send_idle = 35;
        recv_idle = 76;
        test_random(300, 32'd1, 7'd4, 11'd64);
        test_random(250, 32'd7, 7'd64, 11'd1024);
        send_idle = 76;
        recv_idle = 35;
        test_random(300, $urandom, 7'($urandom_range(64)), 11'($urandom_range(1024)));
        test_random(200, 32'hFFFF_FFFF, 7'd1, 11'd16);
        send_idle = 0;
        recv_idle = 0;
        test_backpressure();
        test_random(350, 32'd3, 7'd16, 11'd300);
        test_random(250, 32'd1, 7'd4, 11'd64);

        $display("Covered %0d results: %0d found a session, %0d error statuses, %0d time jumps.",
                 n_results, n_found, n_bad, n_jumps);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
